FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks in the same cycle. Expects clk and rst in the scope of the use.
`define CHECK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Checks in the cycle that follows the antecedent.
`define CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

FILE: sv/tbd_pkg.sv
`timescale 1ns / 1ps

package tbd_pkg;

  localparam int GRID_DEF  = 64;
  localparam int FUNC_W    = 3;
  localparam int STEPS_W   = 6;
  localparam int ROW_IDX_W = 6;
  localparam int ROW_W     = 64;

  typedef logic [ROW_W-1:0] row_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_PEN_UP   = 3'd0,
    FN_PEN_DOWN = 3'd1,
    FN_RIGHT    = 3'd2,
    FN_LEFT     = 3'd3,
    FN_MOVE     = 3'd4,
    FN_DUMP     = 3'd5
  } func_t;

  // Heading: east steps the column up, south steps the row up.
  typedef enum logic [1:0] {
    HD_EAST  = 2'd0,
    HD_SOUTH = 2'd1,
    HD_WEST  = 2'd2,
    HD_NORTH = 2'd3
  } hd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_DUMP
  } state_t;

  typedef struct packed {
    logic set_pen;
    logic pen_val;
    logic turn_r;
    logic turn_l;
    logic load_move;
    logic move_rd;
    logic move_wr;
    logic dump_start;
    logic dump_rd;
  } cmd_t;

  typedef struct packed {
    logic move_zero;
    logic step_last;
    logic row_last;
  } stat_t;

endpackage

FILE: sv/tbd_ctrl.sv
`timescale 1ns / 1ps

module tbd_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tbd_pkg::FUNC_W-1:0] func,
  input  tbd_pkg::stat_t             stat,
  output logic                       busy,
  output tbd_pkg::cmd_t              cmd
);

  tbd_pkg::state_t state;
  tbd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tbd_pkg::ST_IDLE: begin
        if (start) begin
          unique case (tbd_pkg::func_t'(func))
            tbd_pkg::FN_MOVE: begin
              if (!stat.move_zero) begin
                state_next = tbd_pkg::ST_MOVE_RD;
              end
            end
            tbd_pkg::FN_DUMP: state_next = tbd_pkg::ST_DUMP;
            default:          state_next = tbd_pkg::ST_IDLE;
          endcase
        end
      end
      tbd_pkg::ST_MOVE_RD: state_next = tbd_pkg::ST_MOVE_WR;
      tbd_pkg::ST_MOVE_WR: begin
        state_next = stat.step_last ? tbd_pkg::ST_IDLE : tbd_pkg::ST_MOVE_RD;
      end
      tbd_pkg::ST_DUMP: begin
        if (stat.row_last) begin
          state_next = tbd_pkg::ST_IDLE;
        end
      end
      default: state_next = tbd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != tbd_pkg::ST_IDLE);
    unique case (state)
      tbd_pkg::ST_IDLE: begin
        if (start) begin
          unique case (tbd_pkg::func_t'(func))
            tbd_pkg::FN_PEN_UP: begin
              cmd.set_pen = 1'b1;
              cmd.pen_val = 1'b0;
            end
            tbd_pkg::FN_PEN_DOWN: begin
              cmd.set_pen = 1'b1;
              cmd.pen_val = 1'b1;
            end
            tbd_pkg::FN_RIGHT: cmd.turn_r     = 1'b1;
            tbd_pkg::FN_LEFT:  cmd.turn_l     = 1'b1;
            tbd_pkg::FN_MOVE:  cmd.load_move  = 1'b1;
            tbd_pkg::FN_DUMP:  cmd.dump_start = 1'b1;
            default: ;
          endcase
        end
      end
      tbd_pkg::ST_MOVE_RD: cmd.move_rd = 1'b1;
      tbd_pkg::ST_MOVE_WR: cmd.move_wr = 1'b1;
      tbd_pkg::ST_DUMP:    cmd.dump_rd = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: sv/tbd_path.sv
`timescale 1ns / 1ps

module tbd_path #(
  parameter int GRID = tbd_pkg::GRID_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tbd_pkg::STEPS_W-1:0]   steps,
  input  tbd_pkg::cmd_t                 cmd,
  output tbd_pkg::stat_t                stat,
  output logic                          strobe,
  output logic [tbd_pkg::ROW_IDX_W-1:0] row_index,
  output tbd_pkg::row_t                 row_bits,
  output logic                          last_row
);

  localparam int IDX_W = $clog2(GRID);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID - 1);

  logic [IDX_W-1:0]            cur_row;
  logic [IDX_W-1:0]            cur_col;
  logic [IDX_W-1:0]            cur_row_next;
  logic [IDX_W-1:0]            cur_col_next;
  tbd_pkg::hd_t                heading;
  logic                        pen_down;
  logic [tbd_pkg::STEPS_W-1:0] step_cnt;
  logic [IDX_W-1:0]            row_cnt;

  // Row memory. A row that was never written since reset reads as zero.
  tbd_pkg::row_t               mem [GRID];
  logic [GRID-1:0]             vld;
  tbd_pkg::row_t               rd_data;
  logic                        rd_valid;
  logic [IDX_W-1:0]            rd_addr;
  tbd_pkg::row_t               old_row;
  tbd_pkg::row_t               new_row;
  tbd_pkg::row_t               mask;

  logic                        out_stb;
  logic [IDX_W-1:0]            out_idx;
  logic                        out_last;

  assign stat.move_zero = (steps == '0);
  assign stat.step_last = (step_cnt == tbd_pkg::STEPS_W'(1));
  assign stat.row_last  = (row_cnt == LAST_IDX);

  assign rd_addr = cmd.move_rd ? cur_row : row_cnt;
  assign old_row = rd_valid ? rd_data : '0;
  assign mask    = tbd_pkg::row_t'(1) << cur_col;
  assign new_row = pen_down ? (old_row | mask) : (old_row & ~mask);

  always_comb begin
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    unique case (heading)
      tbd_pkg::HD_EAST:  cur_col_next = (cur_col == LAST_IDX) ? '0 : cur_col + IDX_W'(1);
      tbd_pkg::HD_SOUTH: cur_row_next = (cur_row == LAST_IDX) ? '0 : cur_row + IDX_W'(1);
      tbd_pkg::HD_WEST:  cur_col_next = (cur_col == '0) ? LAST_IDX : cur_col - IDX_W'(1);
      tbd_pkg::HD_NORTH: cur_row_next = (cur_row == '0) ? LAST_IDX : cur_row - IDX_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row  <= '0;
      cur_col  <= '0;
      heading  <= tbd_pkg::HD_EAST;
      pen_down <= 1'b0;
      step_cnt <= '0;
      row_cnt  <= '0;
      vld      <= '0;
      out_stb  <= 1'b0;
    end else begin
      if (cmd.set_pen) begin
        pen_down <= cmd.pen_val;
      end
      if (cmd.turn_r) begin
        heading <= tbd_pkg::hd_t'(heading + 2'd1);
      end else if (cmd.turn_l) begin
        heading <= tbd_pkg::hd_t'(heading - 2'd1);
      end
      if (cmd.load_move) begin
        step_cnt <= steps;
      end else if (cmd.move_wr) begin
        step_cnt <= step_cnt - tbd_pkg::STEPS_W'(1);
      end
      if (cmd.move_wr) begin
        vld[cur_row] <= 1'b1;
        cur_row      <= cur_row_next;
        cur_col      <= cur_col_next;
      end
      if (cmd.dump_start) begin
        row_cnt <= '0;
      end else if (cmd.dump_rd) begin
        row_cnt <= row_cnt + IDX_W'(1);
      end
      out_stb <= cmd.dump_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.move_wr) begin
      mem[cur_row] <= new_row;
    end
    if (cmd.move_rd || cmd.dump_rd) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= vld[rd_addr];
    end
    if (cmd.dump_rd) begin
      out_idx  <= row_cnt;
      out_last <= (row_cnt == LAST_IDX);
    end
  end

  assign strobe    = out_stb;
  assign row_index = tbd_pkg::ROW_IDX_W'(out_idx);
  assign row_bits  = old_row;
  assign last_row  = out_last;

endmodule

FILE: sv/turtle_bitmap_drawer.sv
// Channel   Handshake               Ports
// command   start & !busy           func, steps
// rows      strobe (one cycle)      row_index, row_bits, last_row
//
// Pen and turn commands take effect in the acceptance cycle and do not raise busy.
// A move of N steps keeps busy high: each step reads the turtle's row
// from the single-port row memory and writes it back in the next cycle.
// A dump keeps busy high while it reads all rows, one row read per cycle; each row
// is registered after its read, so the last row appears once busy has dropped.
// Reset clears position, heading, pen and the per-row valid flags.
// The receiver cannot stall the rows; they are shown once and not held.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module turtle_bitmap_drawer #(
  parameter int GRID = tbd_pkg::GRID_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [tbd_pkg::FUNC_W-1:0]    func,
  input  logic [tbd_pkg::STEPS_W-1:0]   steps,
  output logic                          strobe,
  output logic [tbd_pkg::ROW_IDX_W-1:0] row_index,
  output logic [tbd_pkg::ROW_W-1:0]     row_bits,
  output logic                          last_row
);

  tbd_pkg::cmd_t  cmd;
  tbd_pkg::stat_t stat;

  tbd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  tbd_path #(
    .GRID (GRID)
  ) u_path (
    .clk       (clk),
    .rst       (rst),
    .steps     (steps),
    .cmd       (cmd),
    .stat      (stat),
    .strobe    (strobe),
    .row_index (row_index),
    .row_bits  (row_bits),
    .last_row  (last_row)
  );

  `CHECK_NEXT(a_dump_busy, start && !busy && func == tbd_pkg::FN_DUMP, busy)
  `CHECK_NEXT(a_turn_quick, start && !busy && cmd.turn_r, !busy)
  `CHECK_NEXT(a_last_gap, strobe && last_row, !strobe)
  `CHECK_NEXT(a_row_order, strobe && !last_row, strobe && row_index == $past(row_index) + 6'd1)
  `CHECK_NOW(a_strobe_busy, strobe && !last_row, busy)

endmodule
